@@ rtl/average_product_correction_defines.svh @@
// Assertion macros used by the port-level checker of the average product correction block.
`ifndef AVERAGE_PRODUCT_CORRECTION_DEFINES_SVH
`define AVERAGE_PRODUCT_CORRECTION_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define APC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apc assertion failed");

// The consequence must hold in the cycle after the antecedent.
`define APC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apc assertion failed");

`endif

@@ rtl/apc_pkg.sv @@
// Package with the types, constants and helpers of the average product correction block.
package apc_pkg;

  localparam int unsigned MAX_COLS_DEF = 256;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SIZE_W       = 9;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned CS_W         = 48;
  localparam int unsigned TOT_W        = 49;
  localparam int unsigned PROD_W       = 2 * CS_W;
  localparam int unsigned Q_W          = 41;
  localparam int unsigned DIFF_W       = 43;
  localparam int unsigned SIZE_RESET   = 2;

  localparam logic [DATA_W-1:0] INT32_MAX_C = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] INT32_MIN_C = 32'h8000_0000;
  localparam logic [Q_W-1:0]    QCAP        = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_phase_e;

  typedef struct packed {
    logic            start;
    logic [CS_W-1:0] a;
    logic [CS_W-1:0] b;
    logic [CS_W-1:0] d;
  } md_req_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = DIFF_W'(signed'({1'b0, INT32_MAX_C}));
    lo = -hi - DIFF_W'(1);
    if (v > hi) begin
      sat32 = INT32_MAX_C;
    end else if (v < lo) begin
      sat32 = INT32_MIN_C;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

@@ rtl/average_product_correction.sv @@
// Average product correction of a square Q16.16 matrix: top level with sequencer and memories.
// A write goes straight into the matrix memory. A read result is registered from the memory
// and then loaded into the output register once the output is not stalled. A run forms the
// column sums and corrects each entry with the shared multiplier and divider (48 + 96 steps
// per entry), which a zero total skips. The input is stalled during reads, runs and output stalls.
// Reset is asynchronous and active low and sets the size to 2; the matrix is undefined.
module average_product_correction #(
  parameter int unsigned MAX_COLS = apc_pkg::MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [apc_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [apc_pkg::IDX_W-1:0]   row_i,
  input  logic [apc_pkg::IDX_W-1:0]   col_i,
  input  logic signed [apc_pkg::DATA_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [apc_pkg::DATA_W-1:0] value_res_o,
  output logic                        is_status_o,
  output logic                        zero_total_o
);

  localparam int unsigned NMAX   = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int unsigned IW     = $clog2(NMAX);
  localparam int unsigned AW     = 2 * IW;
  localparam int unsigned MDEPTH = 1 << AW;
  localparam int unsigned SW     = apc_pkg::SIZE_W;
  localparam int unsigned DW     = apc_pkg::DATA_W;
  localparam int unsigned CW     = apc_pkg::CS_W;
  localparam int unsigned TW     = apc_pkg::TOT_W;
  localparam int unsigned FW     = apc_pkg::DIFF_W;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_READ     = 13'b0000000000010,
    S_SUM_RD   = 13'b0000000000100,
    S_SUM_WR   = 13'b0000000001000,
    S_ROW_RD   = 13'b0000000010000,
    S_ROW_LD   = 13'b0000000100000,
    S_COR_RD   = 13'b0000001000000,
    S_COR_MUL  = 13'b0000010000000,
    S_COR_WAIT = 13'b0000100000000,
    S_COR_WR   = 13'b0001000000000,
    S_FIN_RD   = 13'b0010000000000,
    S_FIN_WR   = 13'b0100000000000,
    S_RESP     = 13'b1000000000000
  } state_e;

  state_e              state_q, state_d;
  logic [SW-1:0]       size_q;
  logic [SW-1:0]       n_eff, n_m1;
  logic [IW-1:0]       i_q, i_d, j_q, j_d;
  logic                j_last, i_last, in_range, in_acc, out_load;
  logic [TW-1:0]       total_q, total_d, total_abs;
  logic [CW-1:0]       tmag_q, csi_q;
  logic                tneg_q, err_q, err_d, rd_inside_q;
  logic [DW-1:0]       mn_q, mn_d;
  logic                out_valid_q;
  logic [DW-1:0]       out_value_q, out_value_d;
  logic                out_status_q, out_status_d, out_zt_q, out_zt_d;

  logic [DW-1:0]       mat_mem [MDEPTH];
  logic [DW-1:0]       mat_rdata_q, mat_wdata;
  logic [AW-1:0]       mat_raddr, mat_waddr;
  logic                mat_re, mat_we;
  logic [CW-1:0]       cs_mem [NMAX];
  logic [CW-1:0]       cs_rdata_q, cs_wdata;
  logic [IW-1:0]       cs_raddr;
  logic                cs_re, cs_we;

  apc_pkg::md_req_t    md_req;
  logic                md_done;
  logic [apc_pkg::Q_W-1:0] md_q;

  logic [CW-1:0]       w_ext, csj_abs, csi_abs;
  logic [FW-1:0]       term, cor_diff, fin_diff;
  logic [DW-1:0]       cor_val, fin_val;

  assign n_eff    = (size_q > SW'(NMAX)) ? SW'(NMAX) : size_q;
  assign n_m1     = n_eff - SW'(1);
  assign j_last   = (SW'(j_q) == n_m1);
  assign i_last   = (SW'(i_q) == n_m1);
  assign in_range = (SW'(row_i) < n_eff) && (SW'(col_i) < n_eff);

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = ((state_q == S_READ) || (state_q == S_RESP))
                      && (!out_valid_q || !out_stall_i);

  // Column sum accumulation.
  assign w_ext    = {{(CW-DW){mat_rdata_q[DW-1]}}, mat_rdata_q};
  assign cs_wdata = ((i_q == '0) ? '0 : cs_rdata_q) + w_ext;
  assign total_abs = total_d[TW-1] ? (TW'(0) - total_d) : total_d;

  // Correction term and saturated differences.
  assign csi_abs = csi_q[CW-1] ? (CW'(0) - csi_q) : csi_q;
  assign csj_abs = cs_rdata_q[CW-1] ? (CW'(0) - cs_rdata_q) : cs_rdata_q;
  assign md_req.start = (state_q == S_COR_MUL);
  assign md_req.a     = csi_abs;
  assign md_req.b     = csj_abs;
  assign md_req.d     = tmag_q;

  always_comb begin
    if (err_q) begin
      term = '0;
    end else if (csi_q[CW-1] ^ cs_rdata_q[CW-1] ^ tneg_q) begin
      term = FW'(0) - FW'(md_q);
    end else begin
      term = FW'(md_q);
    end
    cor_diff = {{(FW-DW){mat_rdata_q[DW-1]}}, mat_rdata_q} - term;
    fin_diff = {{(FW-DW){mat_rdata_q[DW-1]}}, mat_rdata_q}
             - {{(FW-DW){mn_q[DW-1]}}, mn_q};
    cor_val  = apc_pkg::sat32(cor_diff);
    fin_val  = (i_q == j_q) ? '0 : apc_pkg::sat32(fin_diff);
  end

  apc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .done_o (md_done),
    .q_o    (md_q)
  );

  // Memory port control.
  always_comb begin
    mat_raddr = {i_q, j_q};
    mat_waddr = {i_q, j_q};
    mat_wdata = cor_val;
    mat_re    = 1'b0;
    mat_we    = 1'b0;
    cs_raddr  = j_q;
    cs_re     = 1'b0;
    cs_we     = (state_q == S_SUM_WR);
    unique case (state_q)
      S_IDLE: begin
        mat_raddr = {row_i[IW-1:0], col_i[IW-1:0]};
        mat_waddr = {row_i[IW-1:0], col_i[IW-1:0]};
        mat_wdata = value_i;
        mat_re    = in_acc && (cmd_i == apc_pkg::CMD_READ) && in_range;
        mat_we    = in_acc && (cmd_i == apc_pkg::CMD_WRITE) && in_range;
      end
      S_SUM_RD, S_COR_RD: begin
        mat_re = 1'b1;
        cs_re  = 1'b1;
      end
      S_ROW_RD: begin
        cs_raddr = i_q;
        cs_re    = 1'b1;
      end
      S_FIN_RD: mat_re = 1'b1;
      S_COR_WR: mat_we = 1'b1;
      S_FIN_WR: begin
        mat_we    = 1'b1;
        mat_wdata = fin_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    if (mat_re) begin
      mat_rdata_q <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      cs_mem[j_q] <= cs_wdata;
    end
    if (cs_re) begin
      cs_rdata_q <= cs_mem[cs_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    total_d      = total_q;
    err_d        = err_q;
    mn_d         = mn_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_zt_d     = out_zt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_i)
            apc_pkg::CMD_READ: state_d = S_READ;
            apc_pkg::CMD_RUN: begin
              i_d     = '0;
              j_d     = '0;
              total_d = '0;
              mn_d    = apc_pkg::INT32_MAX_C;
              if (n_eff == '0) begin
                err_d   = 1'b1;
                mn_d    = '0;
                state_d = S_RESP;
              end else begin
                state_d = S_SUM_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_load) begin
          out_value_d  = rd_inside_q ? mat_rdata_q : '0;
          out_status_d = 1'b0;
          out_zt_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_SUM_RD: state_d = S_SUM_WR;
      S_SUM_WR: begin
        total_d = total_q + {{(TW-DW){mat_rdata_q[DW-1]}}, mat_rdata_q};
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            err_d   = (total_d == '0);
            state_d = S_ROW_RD;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = S_SUM_RD;
          end
        end else begin
          j_d     = j_q + IW'(1);
          state_d = S_SUM_RD;
        end
      end
      S_ROW_RD: state_d = S_ROW_LD;
      S_ROW_LD: state_d = S_COR_RD;
      S_COR_RD: state_d = err_q ? S_COR_WR : S_COR_MUL;
      S_COR_MUL: state_d = S_COR_WAIT;
      S_COR_WAIT: begin
        if (md_done) begin
          state_d = S_COR_WR;
        end
      end
      S_COR_WR: begin
        if ((i_q < j_q) && ($signed(cor_val) < $signed(mn_q))) begin
          mn_d = cor_val;
        end
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            state_d = S_FIN_RD;
            if (n_eff < SW'(2)) begin
              mn_d = '0;
            end
          end else begin
            i_d     = i_q + IW'(1);
            state_d = S_ROW_RD;
          end
        end else begin
          j_d     = j_q + IW'(1);
          state_d = S_COR_RD;
        end
      end
      S_FIN_RD: state_d = S_FIN_WR;
      S_FIN_WR: begin
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            state_d = S_RESP;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = S_FIN_RD;
          end
        end else begin
          j_d     = j_q + IW'(1);
          state_d = S_FIN_RD;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_value_d  = mn_q;
          out_status_d = 1'b1;
          out_zt_d     = err_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SW'(apc_pkg::SIZE_RESET);
      i_q         <= '0;
      j_q         <= '0;
      err_q       <= 1'b0;
      mn_q        <= apc_pkg::INT32_MAX_C;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      err_q   <= err_d;
      mn_q    <= mn_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q      <= total_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_zt_q     <= out_zt_d;
    if (state_q == S_ROW_LD) begin
      csi_q <= cs_rdata_q;
    end
    if ((state_q == S_SUM_WR) && j_last && i_last) begin
      tmag_q <= total_abs[CW-1:0];
      tneg_q <= total_d[TW-1];
    end
    if (state_q == S_IDLE) begin
      rd_inside_q <= in_range;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_res_o  = out_value_q;
  assign is_status_o  = out_status_q;
  assign zero_total_o = out_zt_q;

endmodule

@@ rtl/apc_muldiv.sv @@
// Shared shift-add multiplier and restoring divider that forms one capped product term.
module apc_muldiv (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  apc_pkg::md_req_t         req_i,
  output logic                     done_o,
  output logic [apc_pkg::Q_W-1:0]  q_o
);

  localparam int unsigned CNT_W = $clog2(apc_pkg::PROD_W);

  apc_pkg::md_phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [apc_pkg::PROD_W-1:0]     p_q, p_d;
  logic [apc_pkg::CS_W-1:0]       a_q, a_d, b_q, b_d, d_q, d_d, rem_q, rem_d;
  logic                           done_q, done_d;
  logic [apc_pkg::CS_W:0]         rem_s, rem_sub;
  logic                           ge;

  always_comb begin
    rem_s   = {rem_q, p_q[apc_pkg::PROD_W-1]};
    ge      = rem_s >= {1'b0, d_q};
    rem_sub = rem_s - {1'b0, d_q};
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    unique case (phase_q)
      apc_pkg::MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          b_d     = req_i.b;
          d_d     = req_i.d;
          p_d     = '0;
          cnt_d   = '0;
          phase_d = apc_pkg::MD_MUL;
        end
      end
      apc_pkg::MD_MUL: begin
        p_d = {p_q[apc_pkg::PROD_W-2:0], 1'b0}
            + (b_q[apc_pkg::CS_W-1] ? apc_pkg::PROD_W'(a_q) : '0);
        b_d = {b_q[apc_pkg::CS_W-2:0], 1'b0};
        if (cnt_q == CNT_W'(apc_pkg::CS_W - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          phase_d = apc_pkg::MD_DIV;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      apc_pkg::MD_DIV: begin
        rem_d = ge ? rem_sub[apc_pkg::CS_W-1:0] : rem_s[apc_pkg::CS_W-1:0];
        p_d   = {p_q[apc_pkg::PROD_W-2:0], ge};
        if (cnt_q == CNT_W'(apc_pkg::PROD_W - 1)) begin
          done_d  = 1'b1;
          phase_d = apc_pkg::MD_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: phase_d = apc_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= apc_pkg::MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign q_o = ((|p_q[apc_pkg::PROD_W-1:apc_pkg::Q_W]) ||
                (p_q[apc_pkg::Q_W-1] && (|p_q[apc_pkg::Q_W-2:0])))
               ? apc_pkg::QCAP : p_q[apc_pkg::Q_W-1:0];

endmodule

@@ rtl/apc_checker.sv @@
// Port-level checker of the average product correction block and its bind statement.
`include "average_product_correction_defines.svh"

module apc_port_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [apc_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  cmd_i,
  input logic [apc_pkg::IDX_W-1:0]   row_i,
  input logic [apc_pkg::IDX_W-1:0]   col_i,
  input logic [apc_pkg::DATA_W-1:0]  value_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [apc_pkg::DATA_W-1:0]  value_res_o,
  input logic                        is_status_o,
  input logic                        zero_total_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `APC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `APC_ASSERT_NEXT(a_read_busy, in_acc && (cmd_i == apc_pkg::CMD_READ), in_stall_o)
  `APC_ASSERT_NOW(a_read_no_zt, out_valid_o && !is_status_o, !zero_total_o)
  `APC_ASSERT_NEXT(a_write_silent, in_acc && (cmd_i == apc_pkg::CMD_WRITE) && !out_valid_o, !out_valid_o)

endmodule

bind average_product_correction apc_port_checker u_apc_checker (.*);

@@ tb/sv/apc_checker.sv @@
// Checker for the average product correction block: predicts results and compares them.
module apc_checker
  import apc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [SIZE_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               cmd_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] value_res_i,
  input  logic                     is_status_i,
  input  logic                     zero_total_i,
  output int unsigned              pending_o,
  output int unsigned              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM = 256;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_status;
    logic                     zero_total;
  } apc_result_t;

  logic signed [DATA_W-1:0] entries [DIM*DIM];
  logic [SIZE_W-1:0]        size_reg;
  apc_result_t              expected_q [$];
  int unsigned              err_cnt;

  assign errors_o = err_cnt;

  function automatic int unsigned size_in_effect();
    return (size_reg > DIM) ? DIM : size_reg;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(longint v);
    if (v > longint'(32'sh7fff_ffff)) return INT32_MAX_C;
    if (v < -longint'(32'sh7fff_ffff) - 1) return INT32_MIN_C;
    return v[DATA_W-1:0];
  endfunction

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    err_cnt++;
  endtask

  task automatic correct_matrix(output logic signed [DATA_W-1:0] min_o, output logic zt_o);
    int unsigned n;
    longint      colsum [DIM];
    longint      total;
    longint      term;
    longint      mn;
    logic [95:0] prod;
    logic [95:0] quot;
    logic        neg;
    n = size_in_effect();
    total = 0;
    for (int j = 0; j < DIM; j++) colsum[j] = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        colsum[j] += longint'(entries[i*DIM+j]);
        total += longint'(entries[i*DIM+j]);
      end
    zt_o = (total == 0);
    if (!zt_o) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          neg = ((colsum[i] < 0) != (colsum[j] < 0)) != (total < 0);
          prod = 96'(mag64(colsum[i])) * 96'(mag64(colsum[j]));
          quot = prod / 96'(mag64(total));
          if (quot > (96'd1 << 40)) quot = 96'd1 << 40;
          term = neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
          entries[i*DIM+j] = clamp32(longint'(entries[i*DIM+j]) - term);
        end
    end
    mn = longint'(32'sh7fff_ffff);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (longint'(entries[i*DIM+j]) < mn) mn = longint'(entries[i*DIM+j]);
    if (n < 2) mn = 0;
    min_o = mn[DATA_W-1:0];
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        entries[i*DIM+j] = clamp32(longint'(entries[i*DIM+j]) - mn);
      entries[i*DIM+i] = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    apc_result_t res;
    apc_result_t want;
    logic        in_range;
    if (!rst_ni) begin
      size_reg <= SIZE_W'(SIZE_RESET);
      err_cnt <= 0;
      pending_o <= 0;
      expected_q.delete();
      for (int k = 0; k < DIM*DIM; k++) entries[k] = '0;
    end else begin
      if (cfg_we_i) size_reg <= cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("result item with nothing expected: value %0d", value_res_i);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (value_res_i !== want.value) report("value_res", value_res_i, want.value);
          if (is_status_i !== want.is_status) report("is_status", is_status_i, want.is_status);
          if (zero_total_i !== want.zero_total)
            report("zero_total", zero_total_i, want.zero_total);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        in_range = (row_i < size_in_effect()) && (col_i < size_in_effect());
        case (cmd_e'(cmd_i))
          CMD_WRITE: if (in_range) entries[row_i*DIM+col_i] = value_i;
          CMD_RUN: begin
            correct_matrix(res.value, res.zero_total);
            res.is_status = 1'b1;
            expected_q.push_back(res);
          end
          CMD_READ: begin
            res.value = in_range ? entries[row_i*DIM+col_i] : '0;
            res.is_status = 1'b0;
            res.zero_total = 1'b0;
            expected_q.push_back(res);
          end
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the average product correction block: stimulus, idling and verdict.
module tb_top;
  import apc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [SIZE_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               cmd = CMD_WRITE;
  logic [IDX_W-1:0]         row = '0;
  logic [IDX_W-1:0]         col = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] value_res;
  logic                     is_status;
  logic                     zero_total;
  int unsigned              pending;
  int unsigned              errors;

  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cur_n = SIZE_RESET;
  int unsigned cycles = 0;
  logic [15:0] written_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  average_product_correction u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cmd_i(cmd), .row_i(row),
    .col_i(col), .value_i(value), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .value_res_o(value_res), .is_status_o(is_status), .zero_total_o(zero_total)
  );

  apc_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cmd_i(cmd), .row_i(row),
    .col_i(col), .value_i(value), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .value_res_i(value_res), .is_status_i(is_status), .zero_total_i(zero_total),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("average_product_correction verification failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
      2: return INT32_MAX_C;
      3: return INT32_MIN_C;
      default: return DATA_W'((int'($urandom_range(0, 64)) - 32) <<< 16);
    endcase
  endfunction

  task automatic send(cmd_e c, int unsigned r, int unsigned k, logic signed [DATA_W-1:0] v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c;
    row <= r[IDX_W-1:0];
    col <= k[IDX_W-1:0];
    value <= v;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (c == CMD_WRITE && r < cur_n && k < cur_n) written_q.push_back({r[7:0], k[7:0]});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_size(int unsigned n, bit fill);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= SIZE_W'(n);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_n = n;
    if (fill)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) send(CMD_WRITE, i, j, pick_value());
  endtask

  task automatic random_items(int unsigned count, bit runs_ok);
    int unsigned done;
    int unsigned r;
    int unsigned k;
    int unsigned sel;
    logic [15:0] rc;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 99);
      if (runs_ok && sel < 6) begin
        send(CMD_RUN, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        done++;
      end else if (sel < 50) begin
        r = $urandom_range(0, cur_n - 1);
        k = $urandom_range(0, cur_n - 1);
        if (cur_n < 256 && $urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) r = $urandom_range(cur_n, 255);
          else k = $urandom_range(cur_n, 255);
        end
        send(CMD_WRITE, r, k, pick_value());
        done++;
      end else if (sel < 92) begin
        rc = written_q[$urandom_range(0, written_q.size() - 1)];
        r = rc[15:8];
        k = rc[7:0];
        if ((cur_n < 256 && $urandom_range(0, 6) == 0) || r >= cur_n || k >= cur_n) begin
          if (cur_n < 256) begin
            r = $urandom_range(0, 255);
            k = $urandom_range(cur_n, 255);
            if ($urandom_range(0, 1)) begin
              r = k;
              k = $urandom_range(0, 255);
            end
          end else begin
            r = 0;
            k = 0;
            written_q.push_back(16'h0000);
            send(CMD_WRITE, 0, 0, pick_value());
          end
        end
        send(CMD_READ, r, k, $urandom);
        done++;
      end else begin
        send(cmd_e'(2'd3), $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) send(CMD_WRITE, i, j, '0);
    send(CMD_RUN, 0, 0, '0);
    send(CMD_READ, 0, 1, '0);
    send(CMD_WRITE, 0, 0, INT32_MAX_C);
    send(CMD_WRITE, 1, 0, INT32_MAX_C);
    send(CMD_WRITE, 0, 1, INT32_MIN_C);
    send(CMD_WRITE, 1, 1, INT32_MIN_C + 1);
    send(CMD_RUN, 255, 255, 32'hffff_ffff);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) send(CMD_READ, i, j, '0);
    send(CMD_READ, 2, 0, '0);
    send(CMD_READ, 0, 255, '0);
    send(CMD_WRITE, 255, 255, 32'h1234_5678);
    send(cmd_e'(2'd3), 0, 0, '0);
    send(CMD_WRITE, 0, 1, 32'sd65536);
    send(CMD_RUN, 0, 0, '0);
    send(CMD_READ, 1, 0, '0);

    set_size(3, 1'b1);
    random_items(130, 1'b1);
    set_size(256, 1'b0);
    send(CMD_WRITE, 255, 255, INT32_MIN_C);
    send(CMD_READ, 255, 255, '0);
    random_items(150, 1'b0);
    set_size(5, 1'b1);
    hold_req = 1'b1;
    random_items(75, 1'b1);
    drain();
    random_items(75, 1'b1);
    set_size(2, 1'b1);
    random_items(120, 1'b1);
    set_size(8, 1'b1);
    quiet = 1'b1;
    random_items(150, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("average_product_correction verification clean");
    end else begin
      $display("average_product_correction verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/apc_pkg.sv
rtl/apc_muldiv.sv
rtl/average_product_correction.sv
rtl/apc_checker.sv
tb/sv/apc_checker.sv
tb/sv/tb_top.sv
